// File: sv/cmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared constants, codes and types of the complex matrix multiplier.
// ----------------------------------------------------------------------------
package cmm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int ELEM_BITS_DEF = 16;

  localparam int IDX_W  = 3;   // row / column index width
  localparam int DIM_W  = 4;   // size register width
  localparam int OUT_W  = 36;  // product element part width
  localparam int REQ_W  = 2;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_INNER  = 2'd1;
  localparam logic [1:0] REG_COLS_B = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic             first;      // first inner term of an element
    logic             last_term;  // last inner term of an element
    logic             last_elem;  // final element of the product
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_tag_t;

  typedef struct packed {
    logic     valid;
    mac_tag_t tag;
  } seq_issue_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic                    last;
  } out_elem_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > max_dim) begin
      r = max_dim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: sv/cmm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_in_if
// Request channel: element loads and compute requests.
// ----------------------------------------------------------------------------
interface cmm_in_if #(
  parameter int ELEM_BITS = cmm_pkg::ELEM_BITS_DEF
) ();
  logic                                valid;
  logic                                ready;
  logic [cmm_pkg::REQ_W-1:0]           req_type;
  logic [cmm_pkg::IDX_W-1:0]           elem_row;
  logic [cmm_pkg::IDX_W-1:0]           elem_col;
  logic signed [ELEM_BITS-1:0]         elem_real;
  logic signed [ELEM_BITS-1:0]         elem_imag;

  modport source (output valid, req_type, elem_row, elem_col, elem_real, elem_imag,
                  input ready);
  modport sink   (input valid, req_type, elem_row, elem_col, elem_real, elem_imag,
                  output ready);
endinterface

// File: sv/cmm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_out_if
// Result channel: one product element per transaction.
// ----------------------------------------------------------------------------
interface cmm_out_if ();
  logic                              valid;
  logic                              ready;
  logic [cmm_pkg::IDX_W-1:0]         out_row;
  logic [cmm_pkg::IDX_W-1:0]         out_col;
  logic signed [cmm_pkg::OUT_W-1:0]  out_real;
  logic signed [cmm_pkg::OUT_W-1:0]  out_imag;
  logic                              out_last;

  modport source (output valid, out_row, out_col, out_real, out_imag, out_last,
                  input ready);
  modport sink   (input valid, out_row, out_col, out_real, out_imag, out_last,
                  output ready);
endinterface

// File: sv/complex_matrix_multiply_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_matrix_multiply_core
// Complex matrix multiplier P = A * B with element stores in RAM.
// ----------------------------------------------------------------------------
// Load transactions (req_type load A / load B) write one complex element,
// real part in the low half and imaginary part in the high half of a RAM
// word; writes with a row or column at or beyond MAX_DIM are dropped. A
// compute transaction produces rows_of_a * cols_of_b result transactions in
// row-major order, the final one flagged by out_last. Each element sums
// inner_size terms. Every cycle reads one word of A and one of B (one read
// port per store) and feeds one complex multiply-accumulate, except when an
// element is due to start and the eight-deep result queue has no room for
// it, as when the result channel stalls. The last result passes the read,
// multiply, combine and accumulate stages into the queue. A new request is
// taken from the cycle after the last read. Results are exact two's
// complement sums with 16 fraction bits, wrapping at 36 bits. Size
// registers of 0 act as 1, values above MAX_DIM act as MAX_DIM. Reading an
// element never loaded gives an undefined result. Write the size registers
// only while no compute is pending; no new request is taken during a
// compute.
// ----------------------------------------------------------------------------
module complex_matrix_multiply_core #(
  parameter int MAX_DIM   = cmm_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = cmm_pkg::ELEM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cmm_in_if.sink                      in_chan,
  cmm_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cmm_pkg::CFG_AW-1:0]  paddr,
  input  logic [cmm_pkg::CFG_DW-1:0]  pwdata,
  output logic [cmm_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import cmm_pkg::*;

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DW    = 2 * ELEM_BITS;
  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

  // ---- configuration registers -------------------------------------------
  logic [DIM_W-1:0] rows_a_r, inner_r, cols_b_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_RESET;
      inner_r  <= DIM_RESET;
      cols_b_r <= DIM_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROWS_A: rows_a_r <= pwdata[DIM_W-1:0];
        REG_INNER:  inner_r  <= pwdata[DIM_W-1:0];
        REG_COLS_B: cols_b_r <= pwdata[DIM_W-1:0];
        default: ;   // unmapped register, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROWS_A: prdata = CFG_DW'(rows_a_r);
      REG_INNER:  prdata = CFG_DW'(inner_r);
      REG_COLS_B: prdata = CFG_DW'(cols_b_r);
      default:    prdata = '0;
    endcase
  end

  // ---- request decode ----------------------------------------------------
  logic             busy;
  logic             in_xfer, in_range, we_a, we_b, start;
  logic [AW-1:0]    waddr;
  logic [DW-1:0]    wdata;

  assign in_chan.ready = !busy;
  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign in_range = (int'(in_chan.elem_row) < MAX_DIM) && (int'(in_chan.elem_col) < MAX_DIM);
  assign we_a     = in_xfer && in_range && (in_chan.req_type == REQ_LOAD_A);
  assign we_b     = in_xfer && in_range && (in_chan.req_type == REQ_LOAD_B);
  assign start    = in_xfer && (in_chan.req_type == REQ_COMPUTE);
  assign waddr    = AW'(int'(in_chan.elem_row) * MAX_DIM + int'(in_chan.elem_col));
  assign wdata    = {in_chan.elem_imag, in_chan.elem_real};

  // ---- sequencer ---------------------------------------------------------
  seq_issue_t       issue;
  logic [AW-1:0]    raddr_a, raddr_b;
  logic             pop;
  logic [DIM_W-1:0] nr, nk, nc;

  // the user must keep the sizes stable while a compute runs; the block does not enforce it
  assign nr = clamp_dim(rows_a_r, MAX_DIM_V);
  assign nk = clamp_dim(inner_r, MAX_DIM_V);
  assign nc = clamp_dim(cols_b_r, MAX_DIM_V);

  cmm_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .nr      (nr),
    .nk      (nk),
    .nc      (nc),
    .pop     (pop),
    .busy    (busy),
    .issue   (issue),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b)
  );

  // ---- element stores ----------------------------------------------------
  logic [DW-1:0] a_data, b_data;

  cmm_mem #(
    .DEPTH (CELLS),
    .WIDTH (DW)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (a_data)
  );

  cmm_mem #(
    .DEPTH (CELLS),
    .WIDTH (DW)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (b_data)
  );

  // ---- multiply-accumulate and result queue ------------------------------
  logic      push;
  out_elem_t push_elem;

  cmm_mac #(
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .a_data    (a_data),
    .b_data    (b_data),
    .push      (push),
    .push_elem (push_elem)
  );

  cmm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_elem (push_elem),
    .pop       (pop),
    .out_chan  (out_chan)
  );

endmodule

// File: sv/cmm_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_mem
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cmm_mem #(
  parameter int  DEPTH = 64,
  parameter int  WIDTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/cmm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_seq
// Walks rows, columns and inner terms of the product; one read per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module cmm_seq #(
  parameter int  MAX_DIM = cmm_pkg::MAX_DIM_DEF,
  localparam int CELLS   = MAX_DIM * MAX_DIM,
  localparam int AW      = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cmm_pkg::DIM_W-1:0] nr,
  input  logic [cmm_pkg::DIM_W-1:0] nk,
  input  logic [cmm_pkg::DIM_W-1:0] nc,
  input  logic                      pop,
  output logic                      busy,
  output cmm_pkg::seq_issue_t       issue,
  output logic [AW-1:0]             raddr_a,
  output logic [AW-1:0]             raddr_b
);
  import cmm_pkg::*;

  seq_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [OUTQ_CW-1:0] pend_r, pend_nxt;   // elements started, not yet popped
  logic               last_k, last_j, last_i, go, elem_start;

  assign last_k = ({1'b0, k_r} == nk - DIM_W'(1));
  assign last_j = ({1'b0, j_r} == nc - DIM_W'(1));
  assign last_i = ({1'b0, i_r} == nr - DIM_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (go && last_k && last_j && last_i) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy = 1'b0;
    go   = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        busy = 1'b0;
        go   = 1'b0;
      end
      SEQ_RUN: begin
        busy = 1'b1;
        // a new element only starts when the output queue has room for it
        go   = (k_r != '0) || (pend_r < OUTQ_CW'(OUTQ_DEPTH));
      end
      default: begin
        busy = 1'b0;
        go   = 1'b0;
      end
    endcase
  end

  assign elem_start = go && (k_r == '0);

  always_comb begin
    issue.valid         = go;
    issue.tag.first     = (k_r == '0);
    issue.tag.last_term = last_k;
    issue.tag.last_elem = last_k && last_j && last_i;
    issue.tag.row       = i_r;
    issue.tag.col       = j_r;
    raddr_a = AW'(int'(i_r) * MAX_DIM + int'(k_r));
    raddr_b = AW'(int'(k_r) * MAX_DIM + int'(j_r));
  end

  // Index counters
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (state_r == SEQ_IDLE) begin
      i_nxt = '0;
      j_nxt = '0;
      k_nxt = '0;
    end else if (go) begin
      if (last_k) begin
        k_nxt = '0;
        if (last_j) begin
          j_nxt = '0;
          i_nxt = i_r + IDX_W'(1);
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end else begin
        k_nxt = k_r + IDX_W'(1);
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (elem_start && !pop) begin
      pend_nxt = pend_r + OUTQ_CW'(1);
    end else if (!elem_start && pop) begin
      pend_nxt = pend_r - OUTQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// File: sv/cmm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_mac
// Complex multiply-accumulate pipeline: multiply, combine, accumulate.
// ----------------------------------------------------------------------------
module cmm_mac #(
  parameter int ELEM_BITS = cmm_pkg::ELEM_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmm_pkg::seq_issue_t    issue,
  input  logic [2*ELEM_BITS-1:0] a_data,
  input  logic [2*ELEM_BITS-1:0] b_data,
  output logic                   push,
  output cmm_pkg::out_elem_t     push_elem
);
  import cmm_pkg::*;

  localparam int PW = 2 * ELEM_BITS;

  // stage 1: read data arrives with this tag
  logic     s1_valid_r;
  mac_tag_t s1_tag_r;
  // stage 2: partial products
  logic     s2_valid_r;
  mac_tag_t s2_tag_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [PW-1:0] p_rr_nxt, p_ii_nxt, p_ri_nxt, p_ir_nxt;
  // stage 3: complex product
  logic     s3_valid_r;
  mac_tag_t s3_tag_r;
  logic signed [OUT_W-1:0] t_re_r, t_im_r, t_re_nxt, t_im_nxt;
  // accumulator
  logic signed [OUT_W-1:0] acc_re_r, acc_im_r, acc_re_nxt, acc_im_nxt;

  logic signed [ELEM_BITS-1:0] ar, ai, br, bi;

  assign ar = a_data[ELEM_BITS-1:0];
  assign ai = a_data[PW-1:ELEM_BITS];
  assign br = b_data[ELEM_BITS-1:0];
  assign bi = b_data[PW-1:ELEM_BITS];

  always_comb begin
    p_rr_nxt = PW'(ar) * PW'(br);
    p_ii_nxt = PW'(ai) * PW'(bi);
    p_ri_nxt = PW'(ar) * PW'(bi);
    p_ir_nxt = PW'(ai) * PW'(br);
  end

  // sums wrap at the output width
  always_comb begin
    t_re_nxt = OUT_W'(p_rr_r) - OUT_W'(p_ii_r);
    t_im_nxt = OUT_W'(p_ri_r) + OUT_W'(p_ir_r);
  end

  always_comb begin
    if (s3_tag_r.first) begin
      acc_re_nxt = t_re_r;
      acc_im_nxt = t_im_r;
    end else begin
      acc_re_nxt = acc_re_r + t_re_r;
      acc_im_nxt = acc_im_r + t_im_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r <= issue.tag;
    s2_tag_r <= s1_tag_r;
    s3_tag_r <= s2_tag_r;
    p_rr_r   <= p_rr_nxt;
    p_ii_r   <= p_ii_nxt;
    p_ri_r   <= p_ri_nxt;
    p_ir_r   <= p_ir_nxt;
    t_re_r   <= t_re_nxt;
    t_im_r   <= t_im_nxt;
    if (s3_valid_r) begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
    end
  end

  assign push = s3_valid_r && s3_tag_r.last_term;

  always_comb begin
    push_elem.row  = s3_tag_r.row;
    push_elem.col  = s3_tag_r.col;
    push_elem.re   = acc_re_nxt;
    push_elem.im   = acc_im_nxt;
    push_elem.last = s3_tag_r.last_elem;
  end

endmodule

// File: sv/cmm_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_outq
// Small result queue between the accumulator and the result channel.
// ----------------------------------------------------------------------------
module cmm_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cmm_pkg::out_elem_t push_elem,
  output logic               pop,
  cmm_out_if.source          out_chan
);
  import cmm_pkg::*;

  out_elem_t          q [OUTQ_DEPTH];
  logic [OUTQ_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUTQ_CW-1:0] cnt_r, cnt_nxt;
  out_elem_t          head;

  assign pop  = out_chan.valid && out_chan.ready;
  assign head = q[rd_ptr_r];

  always_comb begin
    out_chan.valid    = (cnt_r != '0);
    out_chan.out_row  = head.row;
    out_chan.out_col  = head.col;
    out_chan.out_real = head.re;
    out_chan.out_imag = head.im;
    out_chan.out_last = head.last;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + OUTQ_CW'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - OUTQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr_r] <= push_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OUTQ_PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUTQ_PW'(1);
      end
    end
  end

endmodule
